>>> sv/bft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types, codes and the bucket hash of the bidirectional flow table.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int unsigned IDX_W = 8;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_HEADW, ST_WALK, ST_CMP, ST_SCAN, ST_VIC,
    ST_VRD, ST_UHEAD, ST_UWALK, ST_UCMP, ST_INS, ST_INSW, ST_DONE
  } state_t;

  localparam logic [1:0] OUT_HIT_FWD = 2'd0;
  localparam logic [1:0] OUT_HIT_REV = 2'd1;
  localparam logic [1:0] OUT_NEW_FWD = 2'd2;
  localparam logic [1:0] OUT_NEW_SWP = 2'd3;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  iface;
    logic [31:0] bin;
    logic [31:0] bout;
    logic [7:0]  link;
    logic [31:0] etime;
  } entry_t;

  typedef struct packed {
    logic             live;
    logic             have;
    logic [IDX_W-1:0] idx;
    logic [31:0]      etime;
  } cand_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      etime;
  } twr_t;

  function automatic logic [7:0] hash8(input logic [31:0] s, input logic [31:0] d,
                                       input logic [15:0] sp, input logic [15:0] dp,
                                       input logic [7:0] pr);
    logic [31:0] x;
    x = s ^ d ^ {16'd0, sp} ^ {16'd0, dp} ^ {16'd0, pr, 8'd0};
    return x[15:8];
  endfunction

endpackage

>>> sv/bft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_if
// Packet item channel and result item channel of the flow table.
// ----------------------------------------------------------------------------
interface bft_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [15:0] length;
  logic [7:0]  iface_id;
  logic [31:0] timestamp;

  modport source(output valid, src_addr, dst_addr, src_port, dst_port, protocol, length,
                 iface_id, timestamp, input ready);
  modport sink(input valid, src_addr, dst_addr, src_port, dst_port, protocol, length,
               iface_id, timestamp, output ready);
endinterface

interface bft_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot;
  logic [1:0]  outcome;
  logic        evicted;
  logic [31:0] bytes_in;
  logic [31:0] bytes_out;

  modport source(output valid, slot, outcome, evicted, bytes_in, bytes_out, input ready);
  modport sink(input valid, slot, outcome, evicted, bytes_in, bytes_out, output ready);
endinterface

>>> sv/bft_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_cell
// One entry's timestamp; passes on the older of its own and the candidate.
// ----------------------------------------------------------------------------
module bft_cell #(
  parameter logic [7:0] IDX = 8'd1
) (
  input  logic           clk,
  input  logic           rst,
  input  bft_pkg::twr_t  twr,
  input  bft_pkg::cand_t cin,
  output bft_pkg::cand_t cout
);

  logic [31:0] etime;

  always_ff @(posedge clk) begin
    if (rst) begin
      etime <= 32'd0;
    end else if (twr.en && twr.idx == IDX) begin
      etime <= twr.etime;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else if (cin.live && (!cin.have || etime < cin.etime)) begin
      cout <= '{live: 1'b1, have: 1'b1, idx: IDX, etime: etime};
    end else begin
      cout <= cin;
    end
  end

endmodule

>>> sv/bft_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bft_chain
// Row of timestamp cells; a start item ripples through and leaves the oldest.
// ----------------------------------------------------------------------------
module bft_chain #(
  parameter int unsigned ENTRIES = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  bft_pkg::twr_t  twr,
  input  logic           start,
  output bft_pkg::cand_t best
);

  bft_pkg::cand_t link [ENTRIES+1];

  assign link[0] = '{live: start, have: 1'b0, idx: '0, etime: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bft_cell #(.IDX(8'(g + 1))) u_cell (
      .clk (clk),
      .rst (rst),
      .twr (twr),
      .cin (link[g]),
      .cout(link[g+1])
    );
  end

  assign best = link[ENTRIES];

endmodule

>>> sv/bidirectional_flow_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bidirectional_flow_table_top
// Hashed flow cache: chain lookup in both directions, oldest-entry eviction.
//
// channel  dir  payload
// pkt      in   src_addr dst_addr src_port dst_port protocol length iface_id timestamp
// res      out  slot outcome evicted bytes_in bytes_out
// cfg      in   cfg_we cfg_data (flow age limit)
//
// Hit: the bucket chain is walked to the match. Miss: the start item passes through the
// timestamp cell row to find the oldest entry, then the new entry is inserted; an
// eviction first runs an unlink walk. Each walk step waits on the registered read of
// the entry memory.
// Reset clears bucket valid bits and cell timestamps at once; no sweep.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module bidirectional_flow_table_top #(
  parameter int unsigned ENTRIES    = 255,
  parameter int unsigned HASH_WIDTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  bft_in_if.sink       pkt,
  bft_out_if.source    res
);

  localparam int unsigned HDEPTH = 1 << HASH_WIDTH;
  localparam logic [7:0]  ENT8   = 8'(ENTRIES);

  bft_pkg::state_t state, state_next;

  logic [15:0] fi;
  logic [31:0] k_src, k_dst, now;
  logic [15:0] k_sp, k_dp, k_len;
  logic [7:0]  k_pr, k_if;
  logic [7:0]  cur, steps, vict, vlink;
  logic [31:0] vtime;
  logic [HASH_WIDTH-1:0] vb;

  logic [7:0]  head_mem [HDEPTH];
  logic [HDEPTH-1:0] head_vld;
  logic [7:0]  head_q;
  logic        head_vq;
  logic [HASH_WIDTH-1:0] head_raddr, head_waddr;
  logic        head_we;
  logic [7:0]  head_wdata, head_val;

  bft_pkg::entry_t rec_mem [256];
  bft_pkg::entry_t rec, rec_wdata, hit_rec, new_rec;
  logic [7:0]  rec_raddr, rec_waddr;
  logic        rec_we;

  bft_pkg::twr_t  twr;
  bft_pkg::cand_t best;
  logic           chain_start;

  logic [HASH_WIDTH-1:0] bkt, rec_bkt;
  logic        fwd, rev, fresh, swp;
  logic [1:0]  p_outcome;
  logic [7:0]  p_slot;
  logic        p_evicted;
  logic [31:0] p_bin, p_bout;
  logic        finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      fi <= 16'd60;
    end else if (cfg_we) begin
      fi <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      head_vq  <= 1'b0;
    end else begin
      head_vq <= head_vld[head_raddr];
      if (head_we) begin
        head_vld[head_waddr] <= 1'b1;
      end
    end
  end

  assign head_val = head_vq ? head_q : 8'd0;

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec <= rec_mem[rec_raddr];
  end

  bft_chain #(.ENTRIES(ENTRIES)) u_chain (
    .clk  (clk),
    .rst  (rst),
    .twr  (twr),
    .start(chain_start),
    .best (best)
  );

  assign bkt     = HASH_WIDTH'(bft_pkg::hash8(k_src, k_dst, k_sp, k_dp, k_pr));
  assign rec_bkt = HASH_WIDTH'(bft_pkg::hash8(rec.src, rec.dst, rec.sport, rec.dport, rec.proto));
  assign fwd = k_src == rec.src && k_dst == rec.dst && k_sp == rec.sport &&
               k_dp == rec.dport && k_pr == rec.proto;
  assign rev = k_src == rec.dst && k_dst == rec.src && k_sp == rec.dport &&
               k_dp == rec.sport && k_pr == rec.proto;
  assign fresh = (now < rec.etime) || ((now - rec.etime) < {16'd0, fi});
  assign swp = {k_sp[7:0], k_sp[15:8]} > {k_dp[7:0], k_dp[15:8]};

  always_comb begin
    hit_rec = rec;
    hit_rec.etime = now;
    if (fresh) begin
      if (rec.iface == k_if) begin
        if (fwd) begin
          hit_rec.bin = rec.bin + {16'd0, k_len};
        end else begin
          hit_rec.bout = rec.bout + {16'd0, k_len};
        end
      end
    end else begin
      hit_rec.bin   = fwd ? {16'd0, k_len} : 32'd0;
      hit_rec.bout  = fwd ? 32'd0 : {16'd0, k_len};
      hit_rec.iface = k_if;
    end
  end

  always_comb begin
    new_rec.proto = k_pr;
    new_rec.iface = k_if;
    new_rec.link  = head_val;
    new_rec.etime = now;
    if (swp) begin
      new_rec.src = k_dst; new_rec.dst = k_src;
      new_rec.sport = k_dp; new_rec.dport = k_sp;
      new_rec.bin = 32'd0; new_rec.bout = {16'd0, k_len};
    end else begin
      new_rec.src = k_src; new_rec.dst = k_dst;
      new_rec.sport = k_sp; new_rec.dport = k_dp;
      new_rec.bin = {16'd0, k_len}; new_rec.bout = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bft_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    pkt.ready   = 1'b0;
    head_raddr  = bkt;
    head_we     = 1'b0;
    head_waddr  = bkt;
    head_wdata  = vict;
    rec_raddr   = cur;
    rec_we      = 1'b0;
    rec_waddr   = cur;
    rec_wdata   = hit_rec;
    twr         = '{en: 1'b0, idx: cur, etime: now};
    chain_start = 1'b0;
    finish      = 1'b0;
    case (state)
      bft_pkg::ST_IDLE: begin
        pkt.ready = 1'b1;
        if (pkt.valid) state_next = bft_pkg::ST_HEAD;
      end
      bft_pkg::ST_HEAD: state_next = bft_pkg::ST_HEADW;
      bft_pkg::ST_HEADW: state_next = bft_pkg::ST_WALK;
      bft_pkg::ST_WALK: begin
        if (cur == 8'd0 || steps == ENT8) begin
          chain_start = 1'b1;
          state_next  = bft_pkg::ST_SCAN;
        end else begin
          state_next = bft_pkg::ST_CMP;
        end
      end
      bft_pkg::ST_CMP: begin
        if (fwd || rev) begin
          rec_we     = 1'b1;
          twr.en     = 1'b1;
          finish     = 1'b1;
          state_next = bft_pkg::ST_DONE;
        end else begin
          state_next = bft_pkg::ST_WALK;
        end
      end
      bft_pkg::ST_SCAN: begin
        if (best.live) state_next = bft_pkg::ST_VIC;
      end
      bft_pkg::ST_VIC: begin
        rec_raddr  = vict;
        state_next = (vtime != 32'd0) ? bft_pkg::ST_VRD : bft_pkg::ST_INS;
      end
      bft_pkg::ST_VRD: begin
        head_raddr = rec_bkt;
        state_next = bft_pkg::ST_UHEAD;
      end
      bft_pkg::ST_UHEAD: begin
        if (head_val == vict) begin
          head_we    = 1'b1;
          head_waddr = vb;
          head_wdata = vlink;
          state_next = bft_pkg::ST_INS;
        end else begin
          state_next = bft_pkg::ST_UWALK;
        end
      end
      bft_pkg::ST_UWALK: begin
        if (cur == 8'd0 || steps == ENT8) begin
          state_next = bft_pkg::ST_INS;
        end else begin
          state_next = bft_pkg::ST_UCMP;
        end
      end
      bft_pkg::ST_UCMP: begin
        if (rec.link == vict) begin
          rec_we         = 1'b1;
          rec_wdata      = rec;
          rec_wdata.link = vlink;
          state_next     = bft_pkg::ST_INS;
        end else begin
          state_next = bft_pkg::ST_UWALK;
        end
      end
      bft_pkg::ST_INS: state_next = bft_pkg::ST_INSW;
      bft_pkg::ST_INSW: begin
        rec_we     = 1'b1;
        rec_waddr  = vict;
        rec_wdata  = new_rec;
        head_we    = 1'b1;
        twr        = '{en: 1'b1, idx: vict, etime: now};
        finish     = 1'b1;
        state_next = bft_pkg::ST_DONE;
      end
      bft_pkg::ST_DONE: begin
        if (!res.valid || res.ready) state_next = bft_pkg::ST_IDLE;
      end
      default: state_next = bft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      bft_pkg::ST_IDLE: begin
        if (pkt.valid) begin
          k_src <= pkt.src_addr;  k_dst <= pkt.dst_addr;
          k_sp  <= pkt.src_port;  k_dp  <= pkt.dst_port;
          k_pr  <= pkt.protocol;  k_len <= pkt.length;
          k_if  <= pkt.iface_id;
          now   <= (pkt.timestamp == 32'd0) ? 32'd1 : pkt.timestamp;
        end
      end
      bft_pkg::ST_HEADW: begin
        cur <= head_val; steps <= 8'd0;
      end
      bft_pkg::ST_CMP: begin
        if (fwd || rev) begin
          p_slot <= cur; p_evicted <= 1'b0;
          p_outcome <= fwd ? bft_pkg::OUT_HIT_FWD : bft_pkg::OUT_HIT_REV;
          p_bin <= hit_rec.bin; p_bout <= hit_rec.bout;
        end else begin
          cur <= rec.link; steps <= steps + 8'd1;
        end
      end
      bft_pkg::ST_SCAN: begin
        vict <= best.idx; vtime <= best.etime;
      end
      bft_pkg::ST_VRD: begin
        vlink <= rec.link; vb <= rec_bkt;
      end
      bft_pkg::ST_UHEAD: begin
        cur <= head_val; steps <= 8'd0;
      end
      bft_pkg::ST_UCMP: begin
        cur <= rec.link; steps <= steps + 8'd1;
      end
      bft_pkg::ST_INSW: begin
        p_slot <= vict; p_evicted <= (vtime != 32'd0);
        p_outcome <= swp ? bft_pkg::OUT_NEW_SWP : bft_pkg::OUT_NEW_FWD;
        p_bin <= new_rec.bin; p_bout <= new_rec.bout;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == bft_pkg::ST_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bft_pkg::ST_DONE && (!res.valid || res.ready)) begin
      res.slot      <= p_slot;
      res.outcome   <= p_outcome;
      res.evicted   <= p_evicted;
      res.bytes_in  <= p_bin;
      res.bytes_out <= p_bout;
    end
  end

  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.slot != 8'd0)
    else $error("result slot is zero");

  a_evict_on_new: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.evicted |-> res.outcome[1])
    else $error("eviction reported on a hit");

  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_start |=> state == bft_pkg::ST_SCAN)
    else $error("oldest search started outside scan");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    finish |=> state == bft_pkg::ST_DONE)
    else $error("finished item not held for output");

endmodule
